// ===== sv/valid_fir_convolution_top_defines.svh =====
// ----------------------------------------------------------------------------
// valid_fir_convolution_top_defines
// Assertion macros shared by the filter block; compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef VALID_FIR_CONVOLUTION_TOP_DEFINES_SVH
`define VALID_FIR_CONVOLUTION_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define VFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define VFC_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VFC_ASSERT(label, prop, msg)
`define VFC_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== sv/vfc_pkg.sv =====
// ----------------------------------------------------------------------------
// vfc_pkg
// Types and fixed constants of the streaming valid convolution filter
// ----------------------------------------------------------------------------
package vfc_pkg;

	// fixed datapath geometry
	localparam int MAX_TAPS   = 7;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int OUT_W      = 34;
	localparam int TAP_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int LEAVES     = 8;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_COUNT = 3'd0,
		REG_COEF_0    = 3'd1,
		REG_COEF_1    = 3'd2,
		REG_COEF_2    = 3'd3,
		REG_COEF_3    = 3'd4,
		REG_COEF_4    = 3'd5,
		REG_COEF_5    = 3'd6,
		REG_COEF_6    = 3'd7
	} reg_index_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;

	// configuration write as seen by front and back
	typedef struct packed {
		logic                  write;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// aligned window handed from front to back: taps[k] meets coef_k
	typedef struct packed {
		sample_t [MAX_TAPS-1:0] taps;
		logic                   last;
	} mid_item_t;

	// finished result
	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic                    last;
	} out_item_t;

endpackage

// ===== sv/vfc_fifo.sv =====
// ----------------------------------------------------------------------------
// vfc_fifo
// Small first-in first-out queue of registers with an occupancy count
// ----------------------------------------------------------------------------
module vfc_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic [WIDTH-1:0]                 wdata,
	output logic                             full,
	input  logic                             pop,
	output logic [WIDTH-1:0]                 rdata,
	output logic                             empty,
	output logic [$clog2(DEPTH+1)-1:0]       count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// status
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/vfc_front.sv =====
// ----------------------------------------------------------------------------
// vfc_front
// Takes samples, keeps the delay line and fill count, and queues an aligned
// window for every sample that completes a full filter span
// ----------------------------------------------------------------------------
module vfc_front import vfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_wr_t   cfg,
	input  logic      push,
	input  sample_t   sample_value,
	input  logic      first_sample,
	input  logic      last_sample,
	input  logic      mid_full,
	output logic      mid_push,
	output mid_item_t mid_wdata
);

	logic [TAP_W-1:0] tap_count_q;
	sample_t          window_q [MAX_TAPS-1];
	logic [TAP_W-1:0] fill_q;
	sample_t          cur [MAX_TAPS];
	logic [TAP_W-1:0] taps_eff;
	logic [TAP_W-1:0] count_nxt;
	logic             accept;
	logic             emit;

	assign accept = push && !mid_full;

	// tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_W'(1);
		end else if (cfg.write && (cfg.index == REG_TAP_COUNT)) begin
			tap_count_q <= cfg.data[TAP_W-1:0];
		end
	end

	// current window: new sample followed by the delay line
	always_comb begin
		cur[0] = sample_value;
		for (int k = 1; k < MAX_TAPS; k++) begin
			cur[k] = window_q[k-1];
		end
	end

	// fill count and result decision
	always_comb begin
		taps_eff  = (tap_count_q > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : tap_count_q;
		count_nxt = first_sample ? '0 : fill_q;
		if (count_nxt < TAP_W'(MAX_TAPS)) begin
			count_nxt = count_nxt + 1'b1;
		end
		emit = (count_nxt >= taps_eff);
	end

	// align window so that coef_0 meets the oldest sample of the span
	always_comb begin
		for (int k = 0; k < MAX_TAPS; k++) begin
			if (TAP_W'(k) < taps_eff) begin
				mid_wdata.taps[k] = cur[taps_eff - TAP_W'(k) - 1'b1];
			end else begin
				mid_wdata.taps[k] = '0;
			end
		end
		mid_wdata.last = last_sample;
	end

	assign mid_push = accept && emit;

	// delay line and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int k = 0; k < MAX_TAPS - 1; k++) begin
				window_q[k] <= '0;
			end
		end else if (accept) begin
			fill_q <= count_nxt;
			for (int k = 0; k < MAX_TAPS - 1; k++) begin
				window_q[k] <= cur[k];
			end
		end
	end

endmodule

// ===== sv/vfc_back.sv =====
// ----------------------------------------------------------------------------
// vfc_back
// Coefficient registers, multiply stage, adder tree and result queue; draws
// windows from the middle queue only while the result queue has room
// ----------------------------------------------------------------------------
module vfc_back import vfc_pkg::*; #(
	parameter int OUT_DEPTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_wr_t                 cfg,
	input  mid_item_t               mid_rdata,
	input  logic                    mid_empty,
	output logic                    mid_pop,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [OUT_W-1:0] output_value,
	output logic                    last_output
);

	localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
	localparam int USED_W = CNT_W + 2;
	localparam int S2_W   = PROD_W + 1;
	localparam int S3_W   = PROD_W + 2;
	localparam int SUM_W  = PROD_W + 3;

	coef_t                   coef_q [MAX_TAPS];
	prod_t                   prod_s1 [LEAVES];
	logic signed [S2_W-1:0]  sum_s2 [LEAVES/2];
	logic signed [S3_W-1:0]  sum_s3 [LEAVES/4];
	logic                    valid_s1;
	logic                    valid_s2;
	logic                    valid_s3;
	logic                    last_s1;
	logic                    last_s2;
	logic                    last_s3;
	logic signed [SUM_W-1:0] total;
	logic [CNT_W-1:0]        out_count;
	logic [USED_W-1:0]       used;
	logic                    out_full;
	out_item_t               out_wdata;
	out_item_t               out_rdata;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_TAPS; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg.write && (cfg.index != REG_TAP_COUNT)) begin
			coef_q[cfg.index - REG_COEF_0] <= cfg.data[COEF_W-1:0];
		end
	end

	// issue only when the result queue can take everything in flight
	always_comb begin
		used = USED_W'(out_count) + USED_W'(valid_s1) + USED_W'(valid_s2)
			+ USED_W'(valid_s3);
		mid_pop = !mid_empty && !out_full && (used < USED_W'(OUT_DEPTH));
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= mid_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: tap products
	always_ff @(posedge clk) begin
		last_s1 <= mid_rdata.last;
		for (int k = 0; k < MAX_TAPS; k++) begin
			prod_s1[k] <= prod_t'($signed(coef_q[k])) * prod_t'($signed(mid_rdata.taps[k]));
		end
		for (int k = MAX_TAPS; k < LEAVES; k++) begin
			prod_s1[k] <= '0;
		end
	end

	// stage 2: pair sums
	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		for (int j = 0; j < LEAVES / 2; j++) begin
			sum_s2[j] <= S2_W'(prod_s1[2*j]) + S2_W'(prod_s1[2*j+1]);
		end
	end

	// stage 3: quad sums
	always_ff @(posedge clk) begin
		last_s3 <= last_s2;
		for (int j = 0; j < LEAVES / 4; j++) begin
			sum_s3[j] <= S3_W'(sum_s2[2*j]) + S3_W'(sum_s2[2*j+1]);
		end
	end

	// final add into the result queue
	always_comb begin
		total           = SUM_W'(sum_s3[0]) + SUM_W'(sum_s3[1]);
		out_wdata.value = total[OUT_W-1:0];
		out_wdata.last  = last_s3;
	end

	vfc_fifo #(
		.DEPTH (OUT_DEPTH),
		.WIDTH ($bits(out_item_t))
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s3),
		.wdata  (out_wdata),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty),
		.count  (out_count)
	);

	assign output_value = out_rdata.value;
	assign last_output  = out_rdata.last;

endmodule

// ===== sv/valid_fir_convolution_top.sv =====
// ----------------------------------------------------------------------------
// valid_fir_convolution_top
// Streaming valid FIR convolution, up to seven taps, Q1.15 in, Q4.30 out
// ----------------------------------------------------------------------------
// Input channel: drive sample_value, first_sample and last_sample with push;
// a transaction completes when push is high and full is low. first_sample
// restarts the fill count of a vector; once tap_count samples of the vector
// are in, every sample produces one result.
// Result channel: while empty is low, output_value and last_output show the
// oldest result; a transaction completes when pop is high and empty is low.
// Configuration: cfg_write with cfg_index and cfg_data writes register
// cfg_index in the same edge (0 tap_count, 1..7 coef_0..coef_6); the user
// must write only while the block is idle, which the block does not enforce.
// Throughput: one sample per cycle while full is low, set by the parallel tap multipliers.
// Path: a result becomes visible after its sample has passed the middle
// queue, product stage, two adder stages and result queue.
// Stall: the back end issues a window only when the result queue has room for
// all in-flight results; the middle queue then fills and full rises.
// Reset: queues empty, delay line and fill count cleared, tap_count 1,
// coefficients 0.
// ----------------------------------------------------------------------------
`include "valid_fir_convolution_top_defines.svh"

module valid_fir_convolution_top import vfc_pkg::*; #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         push,
	output logic                         full,
	input  logic signed [SAMPLE_W-1:0]   sample_value,
	input  logic                         first_sample,
	input  logic                         last_sample,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [OUT_W-1:0]      output_value,
	output logic                         last_output
);

	cfg_wr_t                      cfg;
	logic                         mid_push;
	logic                         mid_pop;
	logic                         mid_full;
	logic                         mid_empty;
	mid_item_t                    mid_wdata;
	mid_item_t                    mid_rdata;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

	// configuration bundle
	assign cfg.write = cfg_write;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign full = mid_full;

	vfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.push         (push),
		.sample_value (sample_value),
		.first_sample (first_sample),
		.last_sample  (last_sample),
		.mid_full     (mid_full),
		.mid_push     (mid_push),
		.mid_wdata    (mid_wdata)
	);

	vfc_fifo #(
		.DEPTH (MID_DEPTH),
		.WIDTH ($bits(mid_item_t))
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	vfc_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.mid_rdata    (mid_rdata),
		.mid_empty    (mid_empty),
		.mid_pop      (mid_pop),
		.empty        (empty),
		.pop          (pop),
		.output_value (output_value),
		.last_output  (last_output)
	);

	// checks
	`VFC_ASSERT_RST(a_reset_empty, !arst_n |=> empty, "result queue not empty after reset")
	`VFC_ASSERT(a_mid_push_accepted, mid_push |-> (push && !full), "window queued without a transaction")
	`VFC_ASSERT(a_mid_pop_nonempty, mid_pop |-> (!mid_empty && (mid_count != '0)), "back end drew from empty queue")

endmodule
